### src/mtep_pkg.sv
package mtep_pkg;

  localparam int unsigned DELTA_W = 28;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;

  localparam logic [2:0] KIND_MSG       = 3'd0;
  localparam logic [2:0] KIND_META_HDR  = 3'd1;
  localparam logic [2:0] KIND_SYSEX_HDR = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd4;
  localparam logic [2:0] KIND_OVERFLOW  = 3'd5;

  localparam logic [1:0] DC_NONE    = 2'd0;
  localparam logic [1:0] DC_ONE     = 2'd1;
  localparam logic [1:0] DC_TWO     = 2'd2;
  localparam logic [1:0] DC_UNKNOWN = 2'd3;

  // Longest variable-length quantity, in bytes.
  localparam logic [2:0] VLV_MAX_BYTES = 3'd4;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [DELTA_W-1:0] delta_time;
    logic [7:0]         status_byte;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic [7:0]         meta_type;
    logic [DELTA_W-1:0] body_length;
    logic [7:0]         payload_byte;
    logic               last_of_event;
  } mtep_res_t;

  // Data bytes that follow a status; DC_UNKNOWN for a status with no defined length.
  function automatic logic [1:0] data_count(input logic [7:0] st);
    logic [1:0] n;
    n = DC_UNKNOWN;
    if (st[7]) begin
      case (st[7:4])
        4'hC, 4'hD: n = DC_ONE;
        HI_SYSTEM: begin
          case (st[3:0])
            4'h2: n = DC_TWO;
            4'h3: n = DC_ONE;
            4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE: n = DC_NONE;
            default: n = DC_UNKNOWN;
          endcase
        end
        default: n = DC_TWO;
      endcase
    end
    return n;
  endfunction

endpackage

### src/mtep_in_if.sv
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;

  modport source (output valid, output track_byte, input ready);
  modport sink (input valid, input track_byte, output ready);
endinterface

### src/mtep_out_if.sv
interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [27:0] delta_time;
  logic [7:0]  status_byte;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [7:0]  meta_type;
  logic [27:0] body_length;
  logic [7:0]  payload_byte;
  logic        last_of_event;

  modport source (
    output valid, output event_kind, output delta_time, output status_byte,
    output first_data, output second_data, output meta_type, output body_length,
    output payload_byte, output last_of_event, input ready
  );
  modport sink (
    input valid, input event_kind, input delta_time, input status_byte,
    input first_data, input second_data, input meta_type, input body_length,
    input payload_byte, input last_of_event, output ready
  );
endinterface

### src/mtep_out_stage.sv
module mtep_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mtep_pkg::mtep_res_t res,
  output logic               load_ok,
  mtep_out_if.source         out_ch
);
  import mtep_pkg::*;

  logic      vld_r, vld_nxt;
  mtep_res_t res_r, res_nxt;

  // Free when empty or when the held beat leaves this cycle.
  assign load_ok = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (load_ok) begin
      vld_nxt = push;
      if (push) begin
        res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.event_kind    = res_r.event_kind;
  assign out_ch.delta_time    = res_r.delta_time;
  assign out_ch.status_byte   = res_r.status_byte;
  assign out_ch.first_data    = res_r.first_data;
  assign out_ch.second_data   = res_r.second_data;
  assign out_ch.meta_type     = res_r.meta_type;
  assign out_ch.body_length   = res_r.body_length;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.last_of_event = res_r.last_of_event;

endmodule

### src/midi_track_event_parser_top.sv
// Timing: a result beat is registered and appears on out_ch in the cycle after the byte that causes it.
// Throughput: one track byte per cycle; the single result register holds one beat and
// in_ch.ready drops only while that register is full and out_ch.ready is low.
// Reset: synchronous, active low; parser returns to expecting a delta byte, running
// status and all held fields clear, the result register empties.
module midi_track_event_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  mtep_in_if.sink    in_ch,
  mtep_out_if.source out_ch
);
  import mtep_pkg::*;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_MTYPE,
    PH_LEN,
    PH_BODY
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [7:0]         run_r, run_nxt;
  logic [7:0]         cur_r, cur_nxt;
  logic [7:0]         held_r, held_nxt;
  logic [7:0]         meta_r, meta_nxt;
  logic [DELTA_W-1:0] rem_r, rem_nxt;

  logic               acc;
  logic               load_ok;
  logic [7:0]         b;
  logic               res_vld;
  mtep_res_t          res;

  logic [7:0]         st;
  logic [1:0]         n_data;
  logic [7:0]         cur_meta;
  logic [DELTA_W-1:0] len_acc;
  logic [DELTA_W-1:0] rem_dec;
  logic [DELTA_W-1:0] dbase;
  logic [DELTA_W-1:0] dacc;
  logic [2:0]         cbase;
  logic [2:0]         cinc;
  logic [2:0]         len_cinc;

  assign in_ch.ready = load_ok;
  assign acc         = in_ch.valid && load_ok;
  assign b           = in_ch.track_byte;

  assign st       = b[7] ? b : run_r;
  assign n_data   = data_count(st);
  assign cur_meta = (cur_r == ST_META) ? meta_r : 8'h00;
  assign len_acc  = {rem_r[DELTA_W-8:0], b[6:0]};
  assign len_cinc = cnt_r + 3'd1;
  assign rem_dec  = rem_r - DELTA_W'(1);
  // Stray phase codes restart the delta from scratch.
  assign dbase    = (phase_r == PH_DELTA) ? delta_r : '0;
  assign cbase    = (phase_r == PH_DELTA) ? cnt_r : 3'd0;
  assign dacc     = {dbase[DELTA_W-8:0], b[6:0]};
  assign cinc     = cbase + 3'd1;

  always_comb begin
    phase_nxt = phase_r;
    delta_nxt = delta_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    cur_nxt   = cur_r;
    held_nxt  = held_r;
    meta_nxt  = meta_r;
    rem_nxt   = rem_r;
    res_vld   = 1'b0;
    res       = '0;
    res.delta_time = delta_r;

    if (acc) begin
      case (phase_r)
        PH_STATUS: begin
          if (b == ST_META) begin
            cur_nxt   = b;
            phase_nxt = PH_MTYPE;
          end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            cur_nxt   = b;
            meta_nxt  = 8'h00;
            rem_nxt   = '0;
            cnt_nxt   = 3'd0;
            phase_nxt = PH_LEN;
          end else begin
            run_nxt = st;
            cur_nxt = st;
            res.status_byte = st;
            if (n_data == DC_UNKNOWN) begin
              res_vld           = 1'b1;
              res.event_kind    = KIND_UNKNOWN;
              res.last_of_event = 1'b1;
              phase_nxt = PH_DELTA;
              delta_nxt = '0;
              cnt_nxt   = 3'd0;
            end else if (b[7]) begin
              if (n_data == DC_NONE) begin
                res_vld           = 1'b1;
                res.event_kind    = KIND_MSG;
                res.last_of_event = 1'b1;
                phase_nxt = PH_DELTA;
                delta_nxt = '0;
                cnt_nxt   = 3'd0;
              end else begin
                phase_nxt = PH_DATA1;
              end
            end else if (n_data == DC_NONE) begin
              // Running status with no data: the byte doubles as the next one-byte delta.
              res_vld           = 1'b1;
              res.event_kind    = KIND_MSG;
              res.last_of_event = 1'b1;
              delta_nxt = DELTA_W'(b);
              cnt_nxt   = 3'd0;
              phase_nxt = PH_STATUS;
            end else if (n_data == DC_ONE) begin
              res_vld           = 1'b1;
              res.event_kind    = KIND_MSG;
              res.first_data    = b;
              res.last_of_event = 1'b1;
              phase_nxt = PH_DELTA;
              delta_nxt = '0;
              cnt_nxt   = 3'd0;
            end else begin
              held_nxt  = b;
              phase_nxt = PH_DATA2;
            end
          end
        end

        PH_DATA1: begin
          if (data_count(cur_r) == DC_ONE) begin
            res_vld           = 1'b1;
            res.event_kind    = KIND_MSG;
            res.status_byte   = cur_r;
            res.first_data    = b;
            res.last_of_event = 1'b1;
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
            cnt_nxt   = 3'd0;
          end else begin
            held_nxt  = b;
            phase_nxt = PH_DATA2;
          end
        end

        PH_DATA2: begin
          res_vld           = 1'b1;
          res.event_kind    = KIND_MSG;
          res.status_byte   = cur_r;
          res.first_data    = held_r;
          res.second_data   = b;
          res.last_of_event = 1'b1;
          phase_nxt = PH_DELTA;
          delta_nxt = '0;
          cnt_nxt   = 3'd0;
        end

        PH_MTYPE: begin
          meta_nxt  = b;
          rem_nxt   = '0;
          cnt_nxt   = 3'd0;
          phase_nxt = PH_LEN;
        end

        PH_LEN: begin
          rem_nxt = len_acc;
          cnt_nxt = len_cinc;
          res.status_byte = cur_r;
          res.meta_type   = cur_meta;
          if (b[7]) begin
            if (len_cinc >= VLV_MAX_BYTES) begin
              res_vld           = 1'b1;
              res.event_kind    = KIND_OVERFLOW;
              res.last_of_event = 1'b1;
              phase_nxt = PH_DELTA;
              delta_nxt = '0;
              cnt_nxt   = 3'd0;
            end
          end else begin
            res_vld           = 1'b1;
            res.event_kind    = (cur_r == ST_META) ? KIND_META_HDR : KIND_SYSEX_HDR;
            res.body_length   = len_acc;
            res.last_of_event = (len_acc == '0);
            if (len_acc == '0) begin
              phase_nxt = PH_DELTA;
              delta_nxt = '0;
              cnt_nxt   = 3'd0;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end

        PH_BODY: begin
          rem_nxt           = rem_dec;
          res_vld           = 1'b1;
          res.event_kind    = KIND_PAYLOAD;
          res.status_byte   = cur_r;
          res.meta_type     = cur_meta;
          res.payload_byte  = b;
          res.last_of_event = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_nxt = PH_DELTA;
            delta_nxt = '0;
            cnt_nxt   = 3'd0;
          end
        end

        default: begin
          delta_nxt = dacc;
          cnt_nxt   = cinc;
          phase_nxt = PH_DELTA;
          if (b[7]) begin
            if (cinc >= VLV_MAX_BYTES) begin
              res_vld           = 1'b1;
              res.event_kind    = KIND_OVERFLOW;
              res.delta_time    = dacc;
              res.last_of_event = 1'b1;
              delta_nxt = '0;
              cnt_nxt   = 3'd0;
            end
          end else begin
            cnt_nxt   = 3'd0;
            phase_nxt = PH_STATUS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      delta_r <= '0;
      cnt_r   <= 3'd0;
      run_r   <= 8'h00;
      cur_r   <= 8'h00;
      held_r  <= 8'h00;
      meta_r  <= 8'h00;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      delta_r <= delta_nxt;
      cnt_r   <= cnt_nxt;
      run_r   <= run_nxt;
      cur_r   <= cur_nxt;
      held_r  <= held_nxt;
      meta_r  <= meta_nxt;
      rem_r   <= rem_nxt;
    end
  end

  mtep_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (acc && res_vld),
    .res     (res),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

endmodule

### src/mtep_checker.sv
module mtep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_first,
  input logic [7:0]  out_second,
  input logic [27:0] out_body_length,
  input logic        out_last
);
  import mtep_pkg::*;

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Take input whenever the result register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Messages, unknown status and overflow always close their event.
  a_single_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_MSG || out_kind == KIND_UNKNOWN ||
                  out_kind == KIND_OVERFLOW) |-> out_last)
    else $error("single-beat event without last flag");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PAYLOAD |->
      out_first == 8'h00 && out_second == 8'h00 && out_body_length == 28'd0)
    else $error("payload beat carries message fields");

endmodule

bind midi_track_event_parser_top mtep_checker u_mtep_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.event_kind),
  .out_first       (out_ch.first_data),
  .out_second      (out_ch.second_data),
  .out_body_length (out_ch.body_length),
  .out_last        (out_ch.last_of_event)
);
